/* hw/rtl/scp_pkg.sv */
// Shared types, Q30 constants and sign-magnitude helpers for the sine/cosine generator.
`default_nettype none

package scp_pkg;

  // Width of a Q30 magnitude inside the polynomial datapath.
  localparam int MAG_W = 32;
  // Width of the first-quadrant angle t (at most pi/2 in Q30).
  localparam int T_W = 31;

  // Q30 constants.
  localparam logic [30:0] Q30_ONE         = 31'd1073741824;
  localparam logic [30:0] Q30_HALF_PI     = 31'd1686629713;
  localparam logic [29:0] Q30_TWO_OVER_PI = 30'd683565276;
  localparam logic [63:0] Q30_RND         = 64'd536870912;

  // Signed Q30 value held as sign and magnitude.
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } sm_t;

  // Side information that travels with each beat.
  typedef struct packed {
    logic           is_cos;
    logic           neg;
    logic [1:0]     quad;
    logic [T_W-1:0] t;
  } side_t;

  // Constant one in sign-magnitude form.
  localparam sm_t SM_ONE = '{neg: 1'b0, mag: 32'd1073741824};

  // Taylor coefficients c0..c3 for the polynomial in s = t*t.
  function automatic sm_t poly_coef(input logic is_cos, input logic [1:0] idx);
    sm_t c;
    c = '{neg: 1'b0, mag: '0};
    if (is_cos) begin
      case (idx)
        2'd0:    c = '{neg: 1'b1, mag: 32'd536870912};
        2'd1:    c = '{neg: 1'b0, mag: 32'd44739243};
        2'd2:    c = '{neg: 1'b1, mag: 32'd1491308};
        default: c = '{neg: 1'b0, mag: 32'd26631};
      endcase
    end else begin
      case (idx)
        2'd0:    c = '{neg: 1'b1, mag: 32'd178956971};
        2'd1:    c = '{neg: 1'b0, mag: 32'd8947849};
        2'd2:    c = '{neg: 1'b1, mag: 32'd213044};
        default: c = '{neg: 1'b0, mag: 32'd2959};
      endcase
    end
    return c;
  endfunction

  // Round a raw product of two Q30 magnitudes back to Q30.
  function automatic sm_t q30_round(input logic [63:0] p, input logic neg);
    logic [63:0] sum;
    sm_t         r;
    sum   = p + Q30_RND;
    r.mag = sum[61:30];
    r.neg = neg && (r.mag != '0);
    return r;
  endfunction

  // Exact sign-magnitude addition; a zero result is positive.
  function automatic sm_t sm_add(input sm_t a, input sm_t b);
    sm_t r;
    if (a.neg == b.neg) begin
      r.neg = a.neg;
      r.mag = a.mag + b.mag;
    end else if (a.mag >= b.mag) begin
      r.neg = a.neg;
      r.mag = a.mag - b.mag;
    end else begin
      r.neg = b.neg;
      r.mag = b.mag - a.mag;
    end
    if (r.mag == '0) begin
      r.neg = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/scp_horner_step.sv */
// One Horner step, acc = coef + s * acc, as a multiply stage and an add stage.
`default_nettype none

module scp_horner_step import scp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [MAG_W-1:0] in_s,
  input  wire sm_t              in_acc,
  input  wire sm_t              in_coef,
  input  wire side_t            in_side,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [MAG_W-1:0]      out_s,
  output sm_t                   out_acc,
  output side_t                 out_side
);

  logic                 prod_valid;
  logic [2*MAG_W-1:0]   prod;
  logic                 prod_neg;
  sm_t                  prod_coef;
  logic [MAG_W-1:0]     prod_s;
  side_t                prod_side;
  logic                 en_prod;
  logic                 en_out;
  sm_t                  term;
  sm_t                  acc_next;

  // A stage loads when it is empty or its content moves on.
  assign en_out   = !out_valid || out_ready;
  assign en_prod  = !prod_valid || en_out;
  assign in_ready = en_prod;

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (en_prod) begin
      prod_valid <= in_valid;
    end
    if (en_prod && in_valid) begin
      prod      <= 64'(in_s) * 64'(in_acc.mag);
      prod_neg  <= in_acc.neg;
      prod_coef <= in_coef;
      prod_s    <= in_s;
      prod_side <= in_side;
    end
  end

  // Round the product and add the coefficient.
  always_comb begin
    term     = q30_round(prod, prod_neg);
    acc_next = sm_add(prod_coef, term);
  end

  // Add stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= prod_valid;
    end
    if (en_out && prod_valid) begin
      out_acc  <= acc_next;
      out_s    <= prod_s;
      out_side <= prod_side;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sine_cosine_polynomial.sv */
// Pipelined sine/cosine generator using fixed Taylor polynomials.
//
// Input channel (arg_valid/arg_ready): angle in radians, signed with
// ANGLE_FRAC_BITS fractional bits, and mode (0 sine, 1 cosine).
// Output channel (res_valid/res_ready): value, signed with
// RESULT_FRAC_BITS fractional bits, saturated to plus or minus one.
// One result beat is produced for every input beat, in order.
//
// Throughput is one beat per cycle while the receiver does not stall:
// the datapath is a chain of 17 registered stages, each holding at most
// one multiplier (phase scale, pi/2 scale, t squared, four Horner steps
// and the final sine multiply) or one round-and-add.
//
// Reset clears every stage valid bit; the block holds no other state.
// When the receiver stalls, the result stays on the output and stages
// behind it keep filling any empty slots; arg_ready drops only once
// every stage holds a beat.
`default_nettype none

module sine_cosine_polynomial import scp_pkg::*; #(
  parameter int ANGLE_FRAC_BITS  = 13,
  parameter int RESULT_FRAC_BITS = 14
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               arg_valid,
  output logic                    arg_ready,
  input  wire logic signed [16:0] angle,
  input  wire logic               mode,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output logic signed [15:0]      value
);

  localparam int HORNER_N = 4;
  localparam int SH = 30 - RESULT_FRAC_BITS;
  localparam logic [32:0] OUT_HALF = 33'((64'd1 << SH) >> 1);
  localparam logic [32:0] OUT_LIM  = 33'(64'd1 << RESULT_FRAC_BITS);

  // Stage 1: absolute angle times 2/pi.
  logic        p1_valid;
  logic [46:0] p1_prod;
  logic        p1_neg;
  logic        p1_cos;
  logic        en1;
  logic [16:0] absx;

  // Stage 2: quadrant and folded fraction.
  logic        p2_valid;
  logic [30:0] p2_f;
  logic [1:0]  p2_quad;
  logic        p2_neg;
  logic        p2_cos;
  logic        en2;
  logic [63:0] phase_full;
  logic [29:0] frac;
  logic [30:0] f_next;

  // Stage 3: fraction times pi/2.
  logic        p3_valid;
  logic [61:0] p3_prod;
  logic [1:0]  p3_quad;
  logic        p3_neg;
  logic        p3_cos;
  logic        en3;

  // Stage 4: rounded angle t.
  logic        p4_valid;
  side_t       p4_side;
  logic        en4;
  sm_t         t_round;

  // Stage 5: t squared.
  logic        p5_valid;
  logic [61:0] p5_prod;
  side_t       p5_side;
  logic        en5;

  // Stage 6: rounded s.
  logic             p6_valid;
  logic [MAG_W-1:0] p6_s;
  side_t            p6_side;
  logic             en6;
  sm_t              s_round;

  // Horner chain.
  logic             h_in_valid [HORNER_N];
  logic             h_in_ready [HORNER_N];
  logic [MAG_W-1:0] h_in_s     [HORNER_N];
  sm_t              h_in_acc   [HORNER_N];
  sm_t              h_in_coef  [HORNER_N];
  side_t            h_in_side  [HORNER_N];
  logic             h_out_valid[HORNER_N];
  logic             h_out_ready[HORNER_N];
  logic [MAG_W-1:0] h_out_s    [HORNER_N];
  sm_t              h_out_acc  [HORNER_N];
  side_t            h_out_side [HORNER_N];

  // Stage 7: final sine multiply by t.
  logic        p7_valid;
  logic [63:0] p7_prod;
  sm_t         p7_acc;
  side_t       p7_side;
  logic        en7;

  // Stage 8: signed result in Q30.
  logic        p8_valid;
  sm_t         p8_y;
  logic        en8;
  sm_t         y_next;
  logic        flip;

  // Stage 9: output rounding and saturation.
  logic        en9;
  logic [32:0] out_rnd;
  logic [32:0] out_mag;
  logic [15:0] value_next;

  // Stall chain: a stage loads when empty or when its beat moves on.
  assign en9       = !res_valid || res_ready;
  assign en8       = !p8_valid || en9;
  assign en7       = !p7_valid || en8;
  assign en6       = !p6_valid || h_in_ready[0];
  assign en5       = !p5_valid || en6;
  assign en4       = !p4_valid || en5;
  assign en3       = !p3_valid || en4;
  assign en2       = !p2_valid || en3;
  assign en1       = !p1_valid || en2;
  assign arg_ready = en1;

  // Magnitude of the angle; the most negative code maps to 2^16 exactly.
  assign absx = angle[16] ? (~angle + 17'd1) : angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en1) begin
      p1_valid <= arg_valid;
    end
    if (en1 && arg_valid) begin
      p1_prod <= 47'(absx) * 47'(Q30_TWO_OVER_PI);
      p1_neg  <= angle[16];
      p1_cos  <= mode;
    end
  end

  // Phase in quarter turns; odd quadrants fold the fraction.
  always_comb begin
    phase_full = 64'(p1_prod) >> ANGLE_FRAC_BITS;
    frac       = phase_full[29:0];
    f_next     = phase_full[30] ? (Q30_ONE - {1'b0, frac}) : {1'b0, frac};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en2) begin
      p2_valid <= p1_valid;
    end
    if (en2 && p1_valid) begin
      p2_f    <= f_next;
      p2_quad <= phase_full[31:30];
      p2_neg  <= p1_neg;
      p2_cos  <= p1_cos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (en3) begin
      p3_valid <= p2_valid;
    end
    if (en3 && p2_valid) begin
      p3_prod <= 62'(p2_f) * 62'(Q30_HALF_PI);
      p3_quad <= p2_quad;
      p3_neg  <= p2_neg;
      p3_cos  <= p2_cos;
    end
  end

  assign t_round = q30_round(64'(p3_prod), 1'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_valid <= 1'b0;
    end else if (en4) begin
      p4_valid <= p3_valid;
    end
    if (en4 && p3_valid) begin
      p4_side.is_cos <= p3_cos;
      p4_side.neg    <= p3_neg;
      p4_side.quad   <= p3_quad;
      p4_side.t      <= t_round.mag[T_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p5_valid <= 1'b0;
    end else if (en5) begin
      p5_valid <= p4_valid;
    end
    if (en5 && p4_valid) begin
      p5_prod <= 62'(p4_side.t) * 62'(p4_side.t);
      p5_side <= p4_side;
    end
  end

  assign s_round = q30_round(64'(p5_prod), 1'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      p6_valid <= 1'b0;
    end else if (en6) begin
      p6_valid <= p5_valid;
    end
    if (en6 && p5_valid) begin
      p6_s    <= s_round.mag;
      p6_side <= p5_side;
    end
  end

  // Horner evaluation: c3 seeds the accumulator, then c2, c1, c0 and one.
  for (genvar k = 0; k < HORNER_N; k++) begin : g_horner
    if (k == 0) begin : g_first
      assign h_in_valid[k] = p6_valid;
      assign h_in_s[k]     = p6_s;
      assign h_in_acc[k]   = poly_coef(p6_side.is_cos, 2'd3);
      assign h_in_side[k]  = p6_side;
    end else begin : g_next
      assign h_in_valid[k]    = h_out_valid[k-1];
      assign h_in_s[k]        = h_out_s[k-1];
      assign h_in_acc[k]      = h_out_acc[k-1];
      assign h_in_side[k]     = h_out_side[k-1];
      assign h_out_ready[k-1] = h_in_ready[k];
    end

    if (k == HORNER_N - 1) begin : g_one
      assign h_in_coef[k] = SM_ONE;
    end else begin : g_coef
      assign h_in_coef[k] = poly_coef(h_in_side[k].is_cos, 2'(HORNER_N - 2 - k));
    end

    scp_horner_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (h_in_valid[k]),
      .in_ready  (h_in_ready[k]),
      .in_s      (h_in_s[k]),
      .in_acc    (h_in_acc[k]),
      .in_coef   (h_in_coef[k]),
      .in_side   (h_in_side[k]),
      .out_valid (h_out_valid[k]),
      .out_ready (h_out_ready[k]),
      .out_s     (h_out_s[k]),
      .out_acc   (h_out_acc[k]),
      .out_side  (h_out_side[k])
    );
  end

  assign h_out_ready[HORNER_N-1] = en7;

  // Sine needs one more multiply by t; cosine passes through.
  always_ff @(posedge clk) begin
    if (rst) begin
      p7_valid <= 1'b0;
    end else if (en7) begin
      p7_valid <= h_out_valid[HORNER_N-1];
    end
    if (en7 && h_out_valid[HORNER_N-1]) begin
      p7_prod <= 64'(h_out_side[HORNER_N-1].t) * 64'(h_out_acc[HORNER_N-1].mag);
      p7_acc  <= h_out_acc[HORNER_N-1];
      p7_side <= h_out_side[HORNER_N-1];
    end
  end

  // Quadrant sign, and sine is odd in the angle.
  always_comb begin
    y_next = p7_side.is_cos ? p7_acc : q30_round(p7_prod, p7_acc.neg);
    if (p7_side.is_cos) begin
      flip = (p7_side.quad == 2'd1) || (p7_side.quad == 2'd2);
    end else begin
      flip = p7_side.quad[1] ^ p7_side.neg;
    end
    y_next.neg = y_next.neg ^ flip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p8_valid <= 1'b0;
    end else if (en8) begin
      p8_valid <= p7_valid;
    end
    if (en8 && p7_valid) begin
      p8_y <= y_next;
    end
  end

  // Round half away from zero, clamp to one, then apply the sign.
  always_comb begin
    out_rnd = ({1'b0, p8_y.mag} + OUT_HALF) >> SH;
    out_mag = (out_rnd > OUT_LIM) ? OUT_LIM : out_rnd;
    if (p8_y.neg && (out_mag != '0)) begin
      value_next = 16'(~out_mag + 33'd1);
    end else begin
      value_next = out_mag[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en9) begin
      res_valid <= p8_valid;
    end
    if (en9 && p8_valid) begin
      value <= value_next;
    end
  end

`ifndef SYNTHESIS
  // No result beat may appear right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result beat valid right after reset");

  // A delivered value never exceeds plus or minus one.
  a_saturated: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (RESULT_FRAC_BITS > 14) ||
                  (($signed(value) <= $signed(17'(OUT_LIM))) &&
                   ($signed(value) >= -$signed(17'(OUT_LIM)))))
    else $error("result beat outside the saturation limit");

  // The stage feeding the output only advances into a free output register.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready && p8_valid) |=> (res_valid && p8_valid))
    else $error("result beat overwritten during a stall");
`endif

endmodule

`default_nettype wire

/* bench/tb_sine_cosine_polynomial.sv */
// Self-checking testbench for the pipelined sine/cosine polynomial generator.
`default_nettype none

module tb_sine_cosine_polynomial;

  localparam int ANGLE_FRAC_BITS  = 13;
  localparam int RESULT_FRAC_BITS = 14;
  // Pipeline depth named at the top of the block, plus margin.
  localparam int DRAIN_SLACK      = 40;
  localparam int LONG_HOLD_CYCLES = 60;

  localparam logic [63:0] Q30_UNIT     = 64'd1073741824;
  localparam logic [63:0] Q30_HALF     = 64'd536870912;
  localparam logic [63:0] Q30_FRAC     = 64'd1073741823;
  localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
  localparam logic [63:0] INV_QTURN    = 64'd683565276;
  localparam int          ANGLE_MAX    = 51472;

  typedef enum logic {
    MODE_SINE   = 1'b0,
    MODE_COSINE = 1'b1
  } fn_mode_t;

  // Signed Q30 value kept as sign and magnitude.
  typedef struct {
    bit          neg;
    logic [63:0] mag;
  } q30_sm_t;

  // One outstanding result with the angle that caused it.
  typedef struct {
    logic signed [16:0] angle;
    fn_mode_t           mode;
    logic [15:0]        value;
  } trig_result_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                arg_valid = 1'b0;
  logic                arg_ready;
  logic signed [16:0]  angle     = '0;
  logic                mode      = 1'b0;
  logic                res_valid;
  logic                res_ready = 1'b0;
  logic signed [15:0]  value;

  trig_result_t pending_results[$];
  int  error_count     = 0;
  int  angles_sent     = 0;
  int  results_checked = 0;
  int  blocked_cycles  = 0;
  bit  idle_enable     = 1'b1;
  bit  hold_request    = 1'b0;

  sine_cosine_polynomial #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .arg_valid(arg_valid),
    .arg_ready(arg_ready),
    .angle    (angle),
    .mode     (mode),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .value    (value)
  );

  always #1 clk = ~clk;

  // Rounded product of two Q30 magnitudes; the sign is the xor of the signs.
  function automatic q30_sm_t q30_mul(input q30_sm_t a, input q30_sm_t b);
    q30_sm_t r;
    r.mag = (a.mag * b.mag + Q30_HALF) >> 30;
    r.neg = (r.mag != 0) && (a.neg != b.neg);
    return r;
  endfunction

  // Exact signed sum; zero is always positive.
  function automatic q30_sm_t q30_add(input q30_sm_t a, input q30_sm_t b);
    q30_sm_t r;
    if (a.neg == b.neg) begin
      r.neg = a.neg;
      r.mag = a.mag + b.mag;
    end else if (a.mag >= b.mag) begin
      r.neg = a.neg;
      r.mag = a.mag - b.mag;
    end else begin
      r.neg = b.neg;
      r.mag = b.mag - a.mag;
    end
    if (r.mag == 0) r.neg = 1'b0;
    return r;
  endfunction

  function automatic q30_sm_t q30_const(input longint k);
    q30_sm_t r;
    r.neg = (k < 0);
    r.mag = (k < 0) ? -k : k;
    return r;
  endfunction

  // Horner evaluation of 1 + s*(c0 + s*(c1 + s*(c2 + s*c3))).
  function automatic q30_sm_t taylor_series(input fn_mode_t m, input q30_sm_t s);
    longint  coef[4];
    q30_sm_t acc;
    if (m == MODE_COSINE) coef = '{-536870912, 44739243, -1491308, 26631};
    else                  coef = '{-178956971, 8947849, -213044, 2959};
    acc = q30_const(coef[3]);
    for (int k = 2; k >= 0; k--) acc = q30_add(q30_const(coef[k]), q30_mul(s, acc));
    return q30_add(q30_const(Q30_UNIT), q30_mul(s, acc));
  endfunction

  // Expected output code for one angle and mode.
  function automatic logic [15:0] predict_trig(input logic signed [16:0] a, input fn_mode_t m);
    bit          neg_angle;
    bit          flip;
    logic [63:0] raw, mag_a, phase, frac, f, mag;
    logic [1:0]  quad;
    q30_sm_t     t, s, y;
    raw       = {47'd0, a};
    neg_angle = a[16];
    mag_a     = neg_angle ? (64'h20000 - raw) : raw;
    phase     = (mag_a * INV_QTURN) >> ANGLE_FRAC_BITS;
    quad      = phase[31:30];
    frac      = phase & Q30_FRAC;
    f         = quad[0] ? (Q30_UNIT - frac) : frac;
    t.neg     = 1'b0;
    t.mag     = (f * HALF_PI_Q30 + Q30_HALF) >> 30;
    s         = q30_mul(t, t);
    if (m == MODE_COSINE) begin
      y    = taylor_series(m, s);
      flip = (quad == 2'd1) || (quad == 2'd2);
    end else begin
      y    = q30_mul(t, taylor_series(m, s));
      flip = (quad >= 2'd2) != neg_angle;
    end
    if (flip) y.neg = ~y.neg;
    mag = (y.mag + (64'd1 << (30 - RESULT_FRAC_BITS - 1))) >> (30 - RESULT_FRAC_BITS);
    if (mag > (64'd1 << RESULT_FRAC_BITS)) mag = 64'd1 << RESULT_FRAC_BITS;
    if (y.neg && mag != 0) mag = -mag;
    return mag[15:0];
  endfunction

  // Mostly legal angles; a quarter use the full 17-bit code range.
  function automatic logic signed [16:0] random_angle();
    if ($urandom_range(0, 3) == 0) return 17'($urandom);
    return 17'(int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX);
  endfunction

  // Offer one beat, optionally after an idle burst, and log its expected result.
  task automatic send_angle(input logic signed [16:0] a, input fn_mode_t m);
    trig_result_t r;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      arg_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    arg_valid <= 1'b1;
    angle     <= a;
    mode      <= m;
    do begin
      @(posedge clk);
      if (!arg_ready) blocked_cycles++;
    end while (!arg_ready);
    r.angle = a;
    r.mode  = m;
    r.value = predict_trig(a, m);
    pending_results.push_back(r);
    angles_sent++;
  endtask

  // Stop offering and wait until every result has come back.
  task automatic wait_for_drain();
    arg_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Quadrant edges, period wrap, the extreme codes and both functions.
  task automatic test_directed();
    logic signed [16:0] corners[12];
    corners = '{17'sd0, 17'sd1, -17'sd1, 17'sd6434, 17'sd12868, -17'sd12868,
                17'sd25736, 17'sd38604, 17'sd51472, -17'sd51472,
                17'sd65535, -17'sd65536};
    foreach (corners[k]) begin
      send_angle(corners[k], MODE_SINE);
      send_angle(corners[k], MODE_COSINE);
    end
  endtask

  task automatic test_random_angles();
    repeat (320) send_angle(random_angle(), fn_mode_t'($urandom_range(0, 1)));
  endtask

  // The receiver holds off long enough that the pipeline fills and stalls its input.
  task automatic test_output_stall();
    idle_enable  = 1'b0;
    hold_request = 1'b1;
    repeat (40) send_angle(random_angle(), fn_mode_t'($urandom_range(0, 1)));
    idle_enable  = 1'b1;
  endtask

  // The sender pauses until the block is empty, then resumes.
  task automatic test_pause_until_drained();
    wait_for_drain();
    repeat (120) send_angle(random_angle(), fn_mode_t'($urandom_range(0, 1)));
  endtask

  // Back-to-back stream with no idling on either side.
  task automatic test_steady_stream();
    idle_enable = 1'b0;
    repeat (150) send_angle(random_angle(), fn_mode_t'($urandom_range(0, 1)));
  endtask

  // Output ready: random stall bursts, one long hold on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        res_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(0, 14)) @(posedge clk);
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest pending prediction.
  always @(posedge clk) begin : check_results
    trig_result_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        $error("value: unexpected result %0d with nothing pending", value);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (value !== want.value) begin
          $error("value: expected %0d, actual %0d (angle %0d, mode %s)",
                 $signed(want.value), value, want.angle, want.mode.name());
          error_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_angles();
    test_output_stall();
    test_pause_until_drained();
    test_steady_stream();
    wait_for_drain();
    repeat (DRAIN_SLACK) @(posedge clk);
    $display("Checked %0d sine/cosine results from %0d angles over the full code range.",
             results_checked, angles_sent);
    $display("Input was held back for %0d cycles during output stalls.", blocked_cycles);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #1000000;
    $display("Timeout with %0d results outstanding.", pending_results.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

/* sine_cosine_polynomial.f */
hw/rtl/scp_pkg.sv
hw/rtl/scp_horner_step.sv
hw/rtl/sine_cosine_polynomial.sv
bench/tb_sine_cosine_polynomial.sv
